// ----- rtl/tmc_pkg.sv -----
// shared types, constants and fixed-point helpers for the matrix compose unit
`default_nettype none
package tmc_pkg;

    typedef logic signed [31:0] t_q16;
    typedef logic signed [32:0] t_q30;
    typedef logic signed [33:0] t_cw;
    typedef logic signed [25:0] t_ang;

    localparam int DEG_FULL    = 23592960;
    localparam int DEG_HALF    = 11796480;
    localparam int DEG_QUARTER = 5898240;
    localparam int CORDIC_STEPS = 18;
    localparam int CORDIC_PER_STAGE = 3;
    localparam int CORDIC_STAGES = CORDIC_STEPS / CORDIC_PER_STAGE;
    localparam int CORDIC_GAIN = 652032874;
    localparam int ONE_Q16 = 65536;

    localparam int LAT_REDUCE  = 3;
    localparam int LAT_CORDIC  = CORDIC_STAGES + 1;
    localparam int LAT_COMPOSE = 5;
    localparam int LAT_FRONT   = LAT_REDUCE + LAT_CORDIC;
    localparam int LAT_TOTAL   = LAT_FRONT + LAT_COMPOSE;

    localparam int ATAN_DEG [CORDIC_STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29
    };

    // q2.30 product, rounded half up
    function automatic t_q30 mul_q30(input t_q30 a, input t_q30 b);
        logic signed [65:0] p;
        p = 66'(a) * 66'(b) + (66'sd1 <<< 29);
        return p[62:30];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/tmc_angle_reduce.sv -----
// angle reduction modulo 360 degrees and fold into [-90, 90]
`default_nettype none
module tmc_angle_reduce (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire tmc_pkg::t_q16 i_angle,
    output tmc_pkg::t_ang      o_angle,
    output logic               o_flip
);
    import tmc_pkg::*;

    localparam logic [33:0] BIAS = 34'(DEG_FULL) * 34'd128;

    logic [33:0] r_u1;
    logic [24:0] r_u2;
    t_ang        r_ang;
    logic        r_flip;
    logic [33:0] n_u1;
    logic [33:0] n_u2;
    t_ang        n_ang;
    logic        n_flip;

    // four conditional subtractions per stage
    always_comb begin
        n_u1 = 34'(i_angle) + BIAS;
        for (int k = 7; k >= 4; k--) begin
            if (n_u1 >= (34'(DEG_FULL) << k)) begin
                n_u1 = n_u1 - (34'(DEG_FULL) << k);
            end
        end
    end

    always_comb begin
        n_u2 = r_u1;
        for (int k = 3; k >= 0; k--) begin
            if (n_u2 >= (34'(DEG_FULL) << k)) begin
                n_u2 = n_u2 - (34'(DEG_FULL) << k);
            end
        end
    end

    always_comb begin
        n_ang  = signed'(26'(r_u2));
        n_flip = 1'b0;
        if (n_ang > 26'sd11796480) begin
            n_ang = n_ang - 26'(DEG_FULL);
        end
        if (n_ang > 26'(DEG_QUARTER)) begin
            n_ang  = n_ang - 26'(DEG_HALF);
            n_flip = 1'b1;
        end else if (n_ang < -26'(DEG_QUARTER)) begin
            n_ang  = n_ang + 26'(DEG_HALF);
            n_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u1   <= n_u1;
            r_u2   <= n_u2[24:0];
            r_ang  <= n_ang;
            r_flip <= n_flip;
        end
    end

    assign o_angle = r_ang;
    assign o_flip  = r_flip;

endmodule
`default_nettype wire

// ----- rtl/tmc_cordic.sv -----
// pipelined rotation cordic in degrees, sine and cosine in q2.30
`default_nettype none
module tmc_cordic (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire tmc_pkg::t_ang i_angle,
    input  wire logic          i_flip,
    output tmc_pkg::t_q30      o_sin,
    output tmc_pkg::t_q30      o_cos
);
    import tmc_pkg::*;

    t_cw  w_x [CORDIC_STAGES];
    t_cw  w_y [CORDIC_STAGES];
    t_ang w_z [CORDIC_STAGES];
    logic w_f [CORDIC_STAGES];
    t_cw  r_x [CORDIC_STAGES];
    t_cw  r_y [CORDIC_STAGES];
    t_ang r_z [CORDIC_STAGES];
    logic r_f [CORDIC_STAGES];
    t_q30 r_sin;
    t_q30 r_cos;

    assign w_x[0] = 34'(CORDIC_GAIN);
    assign w_y[0] = '0;
    assign w_z[0] = i_angle;
    assign w_f[0] = i_flip;

    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
        t_cw  n_x;
        t_cw  n_y;
        t_ang n_z;

        if (s > 0) begin : g_link
            assign w_x[s] = r_x[s-1];
            assign w_y[s] = r_y[s-1];
            assign w_z[s] = r_z[s-1];
            assign w_f[s] = r_f[s-1];
        end

        always_comb begin
            t_cw tx;
            n_x = w_x[s];
            n_y = w_y[s];
            n_z = w_z[s];
            for (int j = 0; j < CORDIC_PER_STAGE; j++) begin
                if (n_z >= 0) begin
                    tx  = n_x - (n_y >>> (s * CORDIC_PER_STAGE + j));
                    n_y = n_y + (n_x >>> (s * CORDIC_PER_STAGE + j));
                    n_z = n_z - 26'(ATAN_DEG[s * CORDIC_PER_STAGE + j]);
                end else begin
                    tx  = n_x + (n_y >>> (s * CORDIC_PER_STAGE + j));
                    n_y = n_y - (n_x >>> (s * CORDIC_PER_STAGE + j));
                    n_z = n_z + 26'(ATAN_DEG[s * CORDIC_PER_STAGE + j]);
                end
                n_x = tx;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[s] <= n_x;
                r_y[s] <= n_y;
                r_z[s] <= n_z;
                r_f[s] <= w_f[s];
            end
        end
    end

    // quadrant fold undone by negation
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= r_f[CORDIC_STAGES-1] ? 33'(-r_y[CORDIC_STAGES-1])
                                          : 33'(r_y[CORDIC_STAGES-1]);
            r_cos <= r_f[CORDIC_STAGES-1] ? 33'(-r_x[CORDIC_STAGES-1])
                                          : 33'(r_x[CORDIC_STAGES-1]);
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule
`default_nettype wire

// ----- rtl/tmc_compose.sv -----
// rotation products, scaling and saturation of the 3x3 block
`default_nettype none
module tmc_compose (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire tmc_pkg::t_q30 i_sx,
    input  wire tmc_pkg::t_q30 i_cx,
    input  wire tmc_pkg::t_q30 i_sy,
    input  wire tmc_pkg::t_q30 i_cy,
    input  wire tmc_pkg::t_q30 i_sz,
    input  wire tmc_pkg::t_q30 i_cz,
    input  wire tmc_pkg::t_q16 i_scl [3],
    input  wire tmc_pkg::t_q16 i_mov [3],
    output tmc_pkg::t_q16      o_mat [3][3],
    output tmc_pkg::t_q16      o_mov [3]
);
    import tmc_pkg::*;

    t_q30 r1_sxsy, r1_cxsy, r1_a00, r1_a01, r1_a02, r1_a10, r1_a11;
    t_q30 r1_a12, r1_a20, r1_a21, r1_a22, r1_sz, r1_cz;
    t_q30 r2_b10, r2_b11, r2_b20, r2_b21, r2_a00, r2_a01, r2_a02;
    t_q30 r2_a10, r2_a11, r2_a12, r2_a20, r2_a21, r2_a22;
    t_q30 r3_rot [3][3];
    logic signed [65:0] r4_p [3][3];
    t_q16 r5_mat [3][3];
    t_q16 r1_scl [3];
    t_q16 r2_scl [3];
    t_q16 r3_scl [3];
    t_q16 r1_mov [3];
    t_q16 r2_mov [3];
    t_q16 r3_mov [3];
    t_q16 r4_mov [3];
    t_q16 r5_mov [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sxsy <= mul_q30(i_sx, i_sy);
            r1_cxsy <= mul_q30(i_cx, i_sy);
            r1_a00  <= mul_q30(i_cy, i_cz);
            r1_a01  <= mul_q30(i_cy, i_sz);
            r1_a02  <= i_sy;
            r1_a10  <= mul_q30(i_cx, i_sz);
            r1_a11  <= mul_q30(i_cx, i_cz);
            r1_a12  <= mul_q30(i_sx, i_cy);
            r1_a20  <= mul_q30(i_sx, i_sz);
            r1_a21  <= mul_q30(i_sx, i_cz);
            r1_a22  <= mul_q30(i_cx, i_cy);
            r1_sz   <= i_sz;
            r1_cz   <= i_cz;

            r2_b10 <= mul_q30(r1_sxsy, r1_cz);
            r2_b11 <= mul_q30(r1_sxsy, r1_sz);
            r2_b20 <= mul_q30(r1_cxsy, r1_cz);
            r2_b21 <= mul_q30(r1_cxsy, r1_sz);
            r2_a00 <= r1_a00;
            r2_a01 <= r1_a01;
            r2_a02 <= r1_a02;
            r2_a10 <= r1_a10;
            r2_a11 <= r1_a11;
            r2_a12 <= r1_a12;
            r2_a20 <= r1_a20;
            r2_a21 <= r1_a21;
            r2_a22 <= r1_a22;

            r3_rot[0][0] <= r2_a00;
            r3_rot[0][1] <= -r2_a01;
            r3_rot[0][2] <= r2_a02;
            r3_rot[1][0] <= r2_b10 + r2_a10;
            r3_rot[1][1] <= r2_a11 - r2_b11;
            r3_rot[1][2] <= -r2_a12;
            r3_rot[2][0] <= r2_a20 - r2_b20;
            r3_rot[2][1] <= r2_b21 + r2_a21;
            r3_rot[2][2] <= r2_a22;

            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r4_p[k][j] <= 66'(r3_rot[k][j]) * 66'(r3_scl[j])
                                  + (66'sd1 <<< 29);
                    // saturate the q16.16 element
                    if ((r4_p[k][j] >>> 30) > 66'sd2147483647) begin
                        r5_mat[k][j] <= 32'sh7fffffff;
                    end else if ((r4_p[k][j] >>> 30) < -66'sd2147483648) begin
                        r5_mat[k][j] <= 32'sh80000000;
                    end else begin
                        r5_mat[k][j] <= r4_p[k][j][61:30];
                    end
                end
            end

            r1_scl <= i_scl;
            r2_scl <= r1_scl;
            r3_scl <= r2_scl;
            r1_mov <= i_mov;
            r2_mov <= r1_mov;
            r3_mov <= r2_mov;
            r4_mov <= r3_mov;
            r5_mov <= r4_mov;
        end
    end

    assign o_mat = r5_mat;
    assign o_mov = r5_mov;

endmodule
`default_nettype wire

// ----- rtl/tmc_row_ser.sv -----
// output register that sends a finished matrix as four row transfers
`default_nettype none
module tmc_row_ser (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  wire tmc_pkg::t_q16 i_mat [3][3],
    input  wire tmc_pkg::t_q16 i_mov [3],
    output logic               o_ready,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [1:0]         o_row_number,
    output tmc_pkg::t_q16      o_elem_col0,
    output tmc_pkg::t_q16      o_elem_col1,
    output tmc_pkg::t_q16      o_elem_col2,
    output tmc_pkg::t_q16      o_elem_col3,
    output logic               o_last_row
);
    import tmc_pkg::*;

    localparam logic [1:0] ROW_LAST = 2'd3;

    logic       r_have;
    logic [1:0] r_row;
    t_q16       r_mat [3][3];
    t_q16       r_mov [3];
    logic       w_take;

    assign w_take  = r_have && !i_stall;
    assign o_ready = !r_have || (w_take && r_row == ROW_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_row  <= '0;
        end else if (i_load) begin
            r_have <= 1'b1;
            r_row  <= '0;
        end else if (w_take) begin
            r_have <= (r_row != ROW_LAST);
            r_row  <= r_row + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mat <= i_mat;
            r_mov <= i_mov;
        end
    end

    always_comb begin
        case (r_row)
            2'd0: begin
                o_elem_col0 = r_mat[0][0];
                o_elem_col1 = r_mat[0][1];
                o_elem_col2 = r_mat[0][2];
                o_elem_col3 = r_mov[0];
            end
            2'd1: begin
                o_elem_col0 = r_mat[1][0];
                o_elem_col1 = r_mat[1][1];
                o_elem_col2 = r_mat[1][2];
                o_elem_col3 = r_mov[1];
            end
            2'd2: begin
                o_elem_col0 = r_mat[2][0];
                o_elem_col1 = r_mat[2][1];
                o_elem_col2 = r_mat[2][2];
                o_elem_col3 = r_mov[2];
            end
            default: begin
                o_elem_col0 = '0;
                o_elem_col1 = '0;
                o_elem_col2 = '0;
                o_elem_col3 = 32'(ONE_Q16);
            end
        endcase
    end

    assign o_valid      = r_have;
    assign o_row_number = r_row;
    assign o_last_row   = (r_row == ROW_LAST);

endmodule
`default_nettype wire

// ----- rtl/transform_matrix_compose_unit.sv -----
// top level: model matrix T * Rx * Ry * Rz * S from a transform, one row per transfer
//
// input channel: i_valid / o_stall carry one transform (translation, three Euler
// angles in degrees, three scale factors, all signed q16.16). a transfer happens
// on a rising edge with i_valid high and o_stall low.
// output channel: o_valid / i_stall carry one matrix row per transfer, rows 0 to 3
// in order, o_last_row high on row 3 (0, 0, 0, 1.0).
// pipeline: 15 stages (3 angle reduction, 7 cordic, 5 products and scaling)
// plus the output register, from which row 0 is offered once a matrix is loaded.
// throughput: limited by the single output channel that sends four rows per
// transform; the pipeline itself takes one transform per cycle while o_stall is
// low and holds several in flight.
// stall: when the receiver stalls, the output register holds its row; once the
// last pipeline stage holds a finished matrix that cannot be loaded, the whole
// pipeline freezes and o_stall rises. nothing is dropped or repeated.
// reset: synchronous, active low; clears all valid bits and the row counter.
`default_nettype none
module transform_matrix_compose_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire tmc_pkg::t_q16 i_move_x,
    input  wire tmc_pkg::t_q16 i_move_y,
    input  wire tmc_pkg::t_q16 i_move_z,
    input  wire tmc_pkg::t_q16 i_angle_x_deg,
    input  wire tmc_pkg::t_q16 i_angle_y_deg,
    input  wire tmc_pkg::t_q16 i_angle_z_deg,
    input  wire tmc_pkg::t_q16 i_factor_x,
    input  wire tmc_pkg::t_q16 i_factor_y,
    input  wire tmc_pkg::t_q16 i_factor_z,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [1:0]         o_row_number,
    output tmc_pkg::t_q16      o_elem_col0,
    output tmc_pkg::t_q16      o_elem_col1,
    output tmc_pkg::t_q16      o_elem_col2,
    output tmc_pkg::t_q16      o_elem_col3,
    output logic               o_last_row
);
    import tmc_pkg::*;

    // pipeline advance: everything moves unless a finished matrix waits
    logic w_en;
    logic w_ser_ready;
    logic [LAT_TOTAL-1:0] r_vld;

    // per-axis angle lanes
    t_q16 w_ang_in [3];
    t_ang w_ang [3];
    logic w_flip [3];
    t_q30 w_sin [3];
    t_q30 w_cos [3];

    // translation and scale ride alongside the angle lanes
    t_q16 r_dmov [LAT_FRONT][3];
    t_q16 r_dscl [LAT_FRONT][3];

    t_q16 w_mat [3][3];
    t_q16 w_mov [3];

    assign w_en    = !r_vld[LAT_TOTAL-1] || w_ser_ready;
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT_TOTAL-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dmov[0] <= '{i_move_x, i_move_y, i_move_z};
            r_dscl[0] <= '{i_factor_x, i_factor_y, i_factor_z};
            for (int s = 1; s < LAT_FRONT; s++) begin
                r_dmov[s] <= r_dmov[s-1];
                r_dscl[s] <= r_dscl[s-1];
            end
        end
    end

    assign w_ang_in[0] = i_angle_x_deg;
    assign w_ang_in[1] = i_angle_y_deg;
    assign w_ang_in[2] = i_angle_z_deg;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        tmc_angle_reduce u_reduce (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_angle (w_ang_in[a]),
            .o_angle (w_ang[a]),
            .o_flip  (w_flip[a])
        );

        tmc_cordic u_cordic (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_angle (w_ang[a]),
            .i_flip  (w_flip[a]),
            .o_sin   (w_sin[a]),
            .o_cos   (w_cos[a])
        );
    end

    tmc_compose u_compose (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_sx  (w_sin[0]),
        .i_cx  (w_cos[0]),
        .i_sy  (w_sin[1]),
        .i_cy  (w_cos[1]),
        .i_sz  (w_sin[2]),
        .i_cz  (w_cos[2]),
        .i_scl (r_dscl[LAT_FRONT-1]),
        .i_mov (r_dmov[LAT_FRONT-1]),
        .o_mat (w_mat),
        .o_mov (w_mov)
    );

    // output register, loaded as the last stage advances
    tmc_row_ser u_row_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (r_vld[LAT_TOTAL-1] && w_en),
        .i_mat        (w_mat),
        .i_mov        (w_mov),
        .o_ready      (w_ser_ready),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_row_number (o_row_number),
        .o_elem_col0  (o_elem_col0),
        .o_elem_col1  (o_elem_col1),
        .o_elem_col2  (o_elem_col2),
        .o_elem_col3  (o_elem_col3),
        .o_last_row   (o_last_row)
    );

    // the pipeline only freezes when its last stage holds a matrix
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_vld[LAT_TOTAL-1])
        else $error("input stalled with no finished matrix waiting");

    // rows of one matrix follow without gaps
    a_rows_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_row |=> o_valid)
        else $error("matrix rows interrupted");

    // a new matrix always starts at row 0
    a_row_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_last_row |=> !o_valid || o_row_number == 2'd0)
        else $error("row sequence did not restart at row 0");

    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_row |=>
            o_row_number == $past(o_row_number) + 2'd1)
        else $error("row number skipped");

endmodule
`default_nettype wire
